FILE: src/bsit_pkg.sv
package bsit_pkg;

  localparam int MAX_BLOCKS = 8;
  localparam int INDEX_BITS = 16;

  localparam int REG_COUNT = 6;
  localparam int ADDR_BITS = 6;
  localparam int DATA_BITS = 64;

  // The offset from a split wraps at the index width, then fits the 16-bit field.
  localparam logic [15:0] OFFSET_MASK =
      (INDEX_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << INDEX_BITS) - 32'd1);

  typedef enum logic [1:0] {
    CMD_SPLIT         = 2'd0,
    CMD_COMBINE_BLOCK = 2'd1,
    CMD_COMBINE_SPIN  = 2'd2,
    CMD_NONE          = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INDEX_OVER = 2'd1,
    ST_BLOCK_OVER = 2'd2,
    ST_OFFSET_OVER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_AXIS_LENGTH  = 3'd0,
    REG_BLOCK_COUNT  = 3'd1,
    REG_ALPHA_COUNT  = 3'd2,
    REG_STARTS_LOW   = 3'd3,
    REG_STARTS_HIGH  = 3'd4,
    REG_SPIN_MASK    = 3'd5,
    REG_SPARE6       = 3'd6,
    REG_SPARE7       = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] index;
    logic [2:0]  block_number;
    logic        spin_beta;
    logic [2:0]  spatial_block;
    logic [15:0] inblock_offset;
  } req_t;

  typedef struct packed {
    logic [15:0] index_out;
    logic [2:0]  block_number_out;
    logic [2:0]  spatial_block_out;
    logic        spin_beta_out;
    logic [15:0] inblock_offset_out;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [15:0]       axis_length;
    logic [3:0]        block_count;
    logic [3:0]        alpha_block_count;
    logic [7:0][15:0]  block_starts;
    logic [7:0]        block_spin_mask;
  } cfg_t;

endpackage

FILE: src/bsit_regs.sv
module bsit_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsit_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [bsit_pkg::DATA_BITS-1:0]     pwdata,
  output logic [bsit_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready,
  output bsit_pkg::cfg_t                     cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_length       <= '0;
      cfg.block_count       <= 4'd1;
      cfg.alpha_block_count <= '0;
      cfg.block_starts      <= '0;
      cfg.block_spin_mask   <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        bsit_pkg::REG_AXIS_LENGTH: cfg.axis_length       <= pwdata[15:0];
        bsit_pkg::REG_BLOCK_COUNT: cfg.block_count       <= pwdata[3:0];
        bsit_pkg::REG_ALPHA_COUNT: cfg.alpha_block_count <= pwdata[3:0];
        bsit_pkg::REG_STARTS_LOW:  cfg.block_starts[3:0] <= pwdata;
        bsit_pkg::REG_STARTS_HIGH: cfg.block_starts[7:4] <= pwdata;
        bsit_pkg::REG_SPIN_MASK:   cfg.block_spin_mask   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bsit_pkg::REG_AXIS_LENGTH: prdata = 64'(cfg.axis_length);
      bsit_pkg::REG_BLOCK_COUNT: prdata = 64'(cfg.block_count);
      bsit_pkg::REG_ALPHA_COUNT: prdata = 64'(cfg.alpha_block_count);
      bsit_pkg::REG_STARTS_LOW:  prdata = cfg.block_starts[3:0];
      bsit_pkg::REG_STARTS_HIGH: prdata = cfg.block_starts[7:4];
      bsit_pkg::REG_SPIN_MASK:   prdata = 64'(cfg.block_spin_mask);
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: src/bsit_xlate.sv
module bsit_xlate #(
  parameter int MAX_BLOCKS = bsit_pkg::MAX_BLOCKS
) (
  input  bsit_pkg::cfg_t cfg,
  input  bsit_pkg::req_t req,
  output bsit_pkg::rsp_t rsp
);

  logic [3:0]  used;
  logic [7:0]  start_le;
  logic [2:0]  found;
  logic        stop;
  logic        beta;
  logic [4:0]  cblk;
  logic [2:0]  cblk_lo;
  logic [15:0] cstart;
  logic [15:0] cend;
  logic [16:0] csize;
  logic        cis_last;

  always_comb begin
    if (cfg.block_count == 4'd0) begin
      used = 4'd1;
    end else if (cfg.block_count > 4'(MAX_BLOCKS)) begin
      used = 4'(MAX_BLOCKS);
    end else begin
      used = cfg.block_count;
    end
  end

  // Split: the search stops at the first block that is not in use or whose start lies above the index.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      start_le[i] = (4'(i) < used) && (cfg.block_starts[i] <= req.index);
    end
    found = '0;
    stop  = 1'b0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (!stop) begin
        if (start_le[i]) begin
          found = 3'(i);
        end else begin
          stop = 1'b1;
        end
      end
    end
  end

  assign beta = cfg.block_spin_mask[found];

  // Combine: the block number may run past eight when built from spin and spatial block.
  always_comb begin
    if (req.command == bsit_pkg::CMD_COMBINE_SPIN) begin
      cblk = 5'(req.spatial_block) + (req.spin_beta ? 5'(cfg.alpha_block_count) : 5'd0);
    end else begin
      cblk = 5'(req.block_number);
    end
    cblk_lo  = cblk[2:0];
    cis_last = (cblk == 5'(used) - 5'd1);
    cstart   = cfg.block_starts[cblk_lo];
    cend     = cis_last ? cfg.axis_length : cfg.block_starts[cblk_lo + 3'd1];
    csize    = (cend > cstart) ? 17'(cend) - 17'(cstart) : 17'd0;
  end

  always_comb begin
    rsp = '0;
    case (req.command)
      bsit_pkg::CMD_SPLIT: begin
        if (req.index >= cfg.axis_length) begin
          rsp.status = bsit_pkg::ST_INDEX_OVER;
        end else begin
          rsp.block_number_out   = found;
          rsp.spin_beta_out      = beta;
          rsp.spatial_block_out  = beta ? found - cfg.alpha_block_count[2:0] : found;
          rsp.inblock_offset_out = (req.index - cfg.block_starts[found]) &
                                   bsit_pkg::OFFSET_MASK;
        end
      end
      bsit_pkg::CMD_COMBINE_BLOCK, bsit_pkg::CMD_COMBINE_SPIN: begin
        if (cblk >= 5'(used)) begin
          rsp.status = bsit_pkg::ST_BLOCK_OVER;
        end else if (17'(req.inblock_offset) >= csize) begin
          rsp.status = bsit_pkg::ST_OFFSET_OVER;
        end else begin
          rsp.index_out = cstart + req.inblock_offset;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/block_segment_index_translate.sv
// Channel  | Handshake             | Payload
// request  | req_valid, req_ready  | req  (bsit_pkg::req_t)
// result   | rsp_valid, rsp_ready  | rsp  (bsit_pkg::rsp_t)
// config   | psel, penable, pwrite | paddr, pwdata, prdata, pready
//
// One item is accepted per cycle while req_ready is high. An accepted item is held
// in the input register, then passes the translation logic into the result register,
// from which its result is taken.
// Reset is synchronous and clears both stage valid bits and the configuration registers.
// A stalled result holds in the result register while the input register still
// takes one more item; ready falls only when both stages are full.
module block_segment_index_translate #(
  parameter int MAX_BLOCKS = bsit_pkg::MAX_BLOCKS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  bsit_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output bsit_pkg::rsp_t                 rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsit_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bsit_pkg::DATA_BITS-1:0] pwdata,
  output logic [bsit_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);

  bsit_pkg::cfg_t cfg;
  bsit_pkg::req_t item;
  bsit_pkg::rsp_t result_next;
  logic           item_valid;
  logic           result_ready;

  bsit_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsit_xlate #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_xlate (
    .cfg (cfg),
    .req (item),
    .rsp (result_next)
  );

  assign result_ready = !rsp_valid || rsp_ready;
  assign req_ready    = !item_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_ready) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (result_ready) begin
      rsp_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && result_ready) begin
      rsp <= result_next;
    end
  end

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !result_ready |=> item_valid && $stable(item))
    else $error("input register lost or changed a stalled item");

  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    item_valid && result_ready |=> rsp_valid)
    else $error("item left the input register without reaching the result register");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != bsit_pkg::ST_OK |->
      rsp.index_out == '0 && rsp.block_number_out == '0 &&
      rsp.spatial_block_out == '0 && !rsp.spin_beta_out &&
      rsp.inblock_offset_out == '0)
    else $error("error result carries nonzero fields");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_ready;
  bsit_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  bsit_pkg::rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bsit_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [bsit_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [bsit_pkg::DATA_BITS-1:0] prdata;
  logic pready;

  block_segment_index_translate dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the translation registers, kept in step with every write.
  logic [15:0] cfg_axis = 16'd0;
  logic [3:0] cfg_count = 4'd1;
  logic [3:0] cfg_alpha = 4'd0;
  logic [7:0][15:0] cfg_starts = '0;
  logic [7:0] cfg_spin = 8'd0;

  bsit_pkg::req_t pending_items[$];
  bsit_pkg::rsp_t expected_results[$];
  int unsigned cycles = 0;
  int fail_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  bsit_pkg::rsp_t want;

  function automatic int used_count();
    if (cfg_count == 0) return 1;
    if (cfg_count > bsit_pkg::MAX_BLOCKS) return bsit_pkg::MAX_BLOCKS;
    return int'(cfg_count);
  endfunction

  // Size of a block in use; the last block ends at the axis length.
  function automatic int span_of(int blk);
    int s;
    int e;
    s = cfg_starts[blk];
    e = (blk == used_count() - 1) ? int'(cfg_axis) : int'(cfg_starts[blk + 1]);
    return (e > s) ? e - s : 0;
  endfunction

  function automatic bsit_pkg::rsp_t rebuild(int blk, logic [15:0] off);
    bsit_pkg::rsp_t o;
    o = '0;
    if (blk >= used_count()) begin
      o.status = bsit_pkg::ST_BLOCK_OVER;
    end else if (int'(off) >= span_of(blk)) begin
      o.status = bsit_pkg::ST_OFFSET_OVER;
    end else begin
      o.index_out = cfg_starts[blk] + off;
    end
    return o;
  endfunction

  function automatic bsit_pkg::rsp_t translate(bsit_pkg::req_t r);
    bsit_pkg::rsp_t o;
    int b;
    int i;
    int n;
    o = '0;
    n = used_count();
    case (bsit_pkg::command_t'(r.command))
      bsit_pkg::CMD_SPLIT: begin
        if (r.index >= cfg_axis) begin
          o.status = bsit_pkg::ST_INDEX_OVER;
        end else begin
          // Indices below the first start still land in block zero.
          b = 0;
          for (i = 0; i < n; i++) begin
            if (cfg_starts[i] > r.index) break;
            b = i;
          end
          o.block_number_out = 3'(b);
          o.spin_beta_out = cfg_spin[b];
          o.spatial_block_out = cfg_spin[b] ? 3'(b - int'(cfg_alpha)) : 3'(b);
          o.inblock_offset_out = (r.index - cfg_starts[b]) & bsit_pkg::OFFSET_MASK;
        end
      end
      bsit_pkg::CMD_COMBINE_BLOCK: o = rebuild(int'(r.block_number), r.inblock_offset);
      bsit_pkg::CMD_COMBINE_SPIN: begin
        // The spatial block plus the alpha count does not wrap.
        o = rebuild(int'(r.spatial_block) + (r.spin_beta ? int'(cfg_alpha) : 0),
                    r.inblock_offset);
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic bsit_pkg::req_t mk(bsit_pkg::command_t c, logic [15:0] idx,
                                        logic [2:0] blk, logic sb,
                                        logic [2:0] sp, logic [15:0] off);
    bsit_pkg::req_t r;
    r.command = c;
    r.index = idx;
    r.block_number = blk;
    r.spin_beta = sb;
    r.spatial_block = sp;
    r.inblock_offset = off;
    return r;
  endfunction

  task automatic queue_item(bsit_pkg::req_t r);
    pending_items.insert(pending_items.size(), r);
  endtask

  // Mostly well-formed lookups that land inside the configured blocks.
  function automatic bsit_pkg::req_t random_item();
    bsit_pkg::req_t r;
    int n;
    int pick;
    int blk;
    int sz;
    r = bsit_pkg::req_t'(41'({$urandom, $urandom}));
    n = used_count();
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      r.command = bsit_pkg::CMD_SPLIT;
      if (cfg_axis != 0 && pick != 0) r.index = 16'($urandom_range(0, cfg_axis - 1));
    end else if (pick < 14) begin
      r.command = bsit_pkg::CMD_COMBINE_BLOCK;
      if (pick != 8) begin
        blk = $urandom_range(0, n - 1);
        r.block_number = 3'(blk);
        sz = span_of(blk);
        if (sz > 0) r.inblock_offset = 16'($urandom_range(0, sz - 1));
      end
    end else if (pick < 19) begin
      r.command = bsit_pkg::CMD_COMBINE_SPIN;
      if (pick != 14) begin
        r.spin_beta = (int'(cfg_alpha) < n) ? 1'($urandom_range(0, 1)) : 1'b0;
        if (r.spin_beta) begin
          blk = $urandom_range(cfg_alpha, n - 1);
          r.spatial_block = 3'(blk - int'(cfg_alpha));
        end else begin
          blk = $urandom_range(0, n - 1);
          r.spatial_block = 3'(blk);
        end
        sz = span_of(blk);
        if (sz > 0) r.inblock_offset = 16'($urandom_range(0, sz - 1));
      end
    end else begin
      r.command = bsit_pkg::CMD_NONE;
    end
    return r;
  endfunction

  task automatic report(string what, int got, int exp_val);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, exp_val);
    fail_count++;
  endtask

  task automatic write_reg(bsit_pkg::reg_index_t r, logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      bsit_pkg::REG_AXIS_LENGTH: cfg_axis = v[15:0];
      bsit_pkg::REG_BLOCK_COUNT: cfg_count = v[3:0];
      bsit_pkg::REG_ALPHA_COUNT: cfg_alpha = v[3:0];
      bsit_pkg::REG_STARTS_LOW: cfg_starts[3:0] = v;
      bsit_pkg::REG_STARTS_HIGH: cfg_starts[7:4] = v;
      bsit_pkg::REG_SPIN_MASK: cfg_spin = v[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] axis, logic [3:0] cnt, logic [3:0] alp,
                            logic [7:0][15:0] st, logic [7:0] mask);
    write_reg(bsit_pkg::REG_AXIS_LENGTH, 64'(axis));
    write_reg(bsit_pkg::REG_BLOCK_COUNT, 64'(cnt));
    write_reg(bsit_pkg::REG_ALPHA_COUNT, 64'(alp));
    write_reg(bsit_pkg::REG_STARTS_LOW, st[3:0]);
    write_reg(bsit_pkg::REG_STARTS_HIGH, st[7:4]);
    write_reg(bsit_pkg::REG_SPIN_MASK, 64'(mask));
  endtask

  task automatic random_config();
    logic [15:0] axis;
    logic [3:0] cnt;
    logic [3:0] alp;
    logic [7:0][15:0] st;
    logic [7:0] mask;
    int unsigned pos;
    int unsigned step;
    int k;
    axis = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 40)) : 16'($urandom);
    cnt = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    alp = ($urandom_range(0, 5) == 0) ? 4'($urandom)
                                      : 4'($urandom_range(0, (cnt > 8) ? 8 : cnt));
    mask = (alp >= 8) ? 8'h00 : 8'(8'hFF << alp);
    if ($urandom_range(0, 3) == 0) mask = 8'($urandom);
    // Non-decreasing starts spread over the axis, now and then not starting at zero; now and then all random.
    pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, axis / 4) : 0;
    step = axis / 8 + 1;
    for (k = 0; k < 8; k++) begin
      st[k] = 16'(pos);
      pos += $urandom_range(0, 2 * step);
      if (pos > 65535) pos = 65535;
    end
    if ($urandom_range(0, 4) == 0) begin
      for (k = 0; k < 8; k++) st[k] = 16'($urandom);
    end
    set_config(axis, cnt, alp, st, mask);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || req_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Request driver: bursts of random length separated by random gaps, some of them empty.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_valid && req_ready) begin
        expected_results.insert(expected_results.size(), translate(req));
      end
      if (!req_valid || req_ready) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_valid <= 1'b0;
        end else begin
          req <= pending_items.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Result backpressure changes character with bits 9 to 7 of the cycle counter.
  always @(posedge clk) begin
    case (cycles[9:7])
      3'd0, 3'd1: rsp_ready <= 1'b1;
      3'd2, 3'd3: rsp_ready <= 1'($urandom_range(0, 1));
      3'd4: rsp_ready <= (cycles[1:0] == 2'b00);
      default: rsp_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_results.size() == 0) begin
        report("result with nothing pending, status", int'(rsp.status), 0);
      end else begin
        want = expected_results.pop_front();
        if (rsp.index_out !== want.index_out)
          report("index_out", int'(rsp.index_out), int'(want.index_out));
        if (rsp.block_number_out !== want.block_number_out)
          report("block_number_out", int'(rsp.block_number_out), int'(want.block_number_out));
        if (rsp.spatial_block_out !== want.spatial_block_out)
          report("spatial_block_out", int'(rsp.spatial_block_out),
                 int'(want.spatial_block_out));
        if (rsp.spin_beta_out !== want.spin_beta_out)
          report("spin_beta_out", int'(rsp.spin_beta_out), int'(want.spin_beta_out));
        if (rsp.inblock_offset_out !== want.inblock_offset_out)
          report("inblock_offset_out", int'(rsp.inblock_offset_out),
                 int'(want.inblock_offset_out));
        if (rsp.status !== want.status)
          report("status", int'(rsp.status), int'(want.status));
      end
    end
  end

  initial begin
    logic [7:0][15:0] st;
    int p;
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: an empty axis, so splits overflow and combines hit empty blocks.
    queue_item(mk(bsit_pkg::CMD_SPLIT, 16'h0000, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_SPLIT, 16'hFFFF, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_COMBINE_BLOCK, 16'h0000, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_COMBINE_SPIN, 16'h0000, 3'd0, 1'b1, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_NONE, 16'hFFFF, 3'd7, 1'b1, 3'd7, 16'hFFFF));
    wait_idle();

    // First block starts late, blocks two and three share a start, and block one is
    // beta although it lies below the alpha count.
    st = {16'd0, 16'd0, 16'd0, 16'd700, 16'd250, 16'd250, 16'd100, 16'd10};
    set_config(16'd1000, 4'd5, 4'd3, st, 8'b0001_1010);
    queue_item(mk(bsit_pkg::CMD_SPLIT, 16'd5, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_SPLIT, 16'd150, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_SPLIT, 16'd250, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_SPLIT, 16'd999, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_SPLIT, 16'd1000, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_COMBINE_BLOCK, 16'h0000, 3'd2, 1'b0, 3'd0, 16'd0));
    queue_item(mk(bsit_pkg::CMD_COMBINE_BLOCK, 16'h0000, 3'd4, 1'b0, 3'd0, 16'd299));
    queue_item(mk(bsit_pkg::CMD_COMBINE_BLOCK, 16'h0000, 3'd4, 1'b0, 3'd0, 16'd300));
    queue_item(mk(bsit_pkg::CMD_COMBINE_BLOCK, 16'h0000, 3'd5, 1'b0, 3'd0, 16'd0));
    queue_item(mk(bsit_pkg::CMD_COMBINE_BLOCK, 16'h0000, 3'd7, 1'b0, 3'd0, 16'hFFFF));
    queue_item(mk(bsit_pkg::CMD_COMBINE_SPIN, 16'h0000, 3'd0, 1'b1, 3'd1, 16'd0));
    queue_item(mk(bsit_pkg::CMD_COMBINE_SPIN, 16'h0000, 3'd0, 1'b1, 3'd2, 16'd0));
    queue_item(mk(bsit_pkg::CMD_COMBINE_SPIN, 16'h0000, 3'd0, 1'b0, 3'd0, 16'd89));
    wait_idle();

    // Full axis with an oversized block count and alpha count, all blocks beta.
    st = {16'hE000, 16'hC000, 16'hA000, 16'h8000, 16'h6000, 16'h4000, 16'h2000, 16'h0000};
    set_config(16'hFFFF, 4'd15, 4'd15, st, 8'hFF);
    queue_item(mk(bsit_pkg::CMD_SPLIT, 16'hFFFE, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_COMBINE_SPIN, 16'h0000, 3'd0, 1'b1, 3'd7, 16'd0));
    queue_item(mk(bsit_pkg::CMD_COMBINE_BLOCK, 16'h0000, 3'd7, 1'b0, 3'd0, 16'h1FFE));
    queue_item(mk(bsit_pkg::CMD_COMBINE_BLOCK, 16'h0000, 3'd7, 1'b0, 3'd0, 16'h1FFF));
    queue_item(mk(bsit_pkg::CMD_NONE, 16'h0000, 3'd0, 1'b0, 3'd0, 16'h0000));
    wait_idle();

    // A block count of zero acts as a single block.
    set_config(16'd1, 4'd0, 4'd0, '0, 8'h00);
    queue_item(mk(bsit_pkg::CMD_SPLIT, 16'd0, 3'd0, 1'b0, 3'd0, 16'h0000));
    queue_item(mk(bsit_pkg::CMD_COMBINE_BLOCK, 16'h0000, 3'd0, 1'b0, 3'd0, 16'd0));
    queue_item(mk(bsit_pkg::CMD_COMBINE_SPIN, 16'h0000, 3'd0, 1'b1, 3'd1, 16'd0));
    wait_idle();

    for (p = 0; p < 10; p++) begin
      random_config();
      for (k = 0; k < 115; k++) queue_item(random_item());
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
